// File: sv/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants of the path forwarding table
// Request and status codes, field widths, the request record and helpers.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int TableEntries = 16;
    localparam int SlotW        = $clog2(TableEntries);
    localparam int CntW         = $clog2(TableEntries + 1);
    localparam int QDepth       = 2;

    typedef enum logic [1:0] {
        REQ_INSTALL = 2'd0,
        REQ_FIND    = 2'd1,
        REQ_REVOKE  = 2'd2,
        REQ_EXPIRE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ARG      = 3'd1,
        ST_ACCESS   = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    localparam logic CFG_BCAST   = 1'b0;
    localparam logic CFG_MAXPROF = 1'b1;

    // Classified request, passed from the front end to the back end.
    typedef struct packed {
        t_req        req;
        logic        arg_bad;
        logic [31:0] owner_path;
        logic [31:0] session;
        logic [15:0] dest;
        logic [15:0] hop;
        logic [7:0]  hops;
        logic [3:0]  profile;
        logic [15:0] mtu;
        logic [3:0]  link;
        logic [31:0] expiry;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        t_status      status;
        logic         hit;
        logic [3:0]   slot;
        logic [15:0]  fwd_hop;
        logic [7:0]   hops_left;
        logic [3:0]   profile;
        logic [15:0]  mtu;
        logic [3:0]   link;
        logic         terminal;
        logic [31:0]  deadline;
        logic         expired;
        logic [4:0]   removed;
    } t_rsp;

    localparam int CmdW = $bits(t_cmd);
    localparam int RspW = $bits(t_rsp);

    function automatic logic deadline_reached(input logic [31:0] now,
                                              input logic [31:0] dl);
        logic [31:0] d;
        d = now - dl;
        return ~d[31];
    endfunction

endpackage

// File: sv/pft_front.sv
// ----------------------------------------------------------------------------
// pft_front: request intake and argument check
// Checks the arguments of one request and pushes a classified command.
// ----------------------------------------------------------------------------
module pft_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [193:0]      i_data,
    output logic              o_push,
    output pft_pkg::t_cmd     o_cmd,
    input  logic              i_full
);
    import pft_pkg::*;

    logic [15:0] r_bcast;
    logic [3:0]  r_maxprof;
    logic [1:0]  w_req;
    logic [15:0] w_owner, w_path, w_dest, w_hop, w_mtu;
    logic [31:0] w_sess, w_exp, w_now;
    logic [7:0]  w_hops;
    logic [3:0]  w_prof, w_link;
    logic        w_key_ok, w_inst_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcast   <= 16'hFFFF;
            r_maxprof <= 4'd7;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BCAST) r_bcast <= i_cfg_data;
            else                        r_maxprof <= i_cfg_data[3:0];
        end
    end

    assign w_req   = i_data[1:0];
    assign w_owner = i_data[17:2];
    assign w_sess  = i_data[49:18];
    assign w_path  = i_data[65:50];
    assign w_dest  = i_data[81:66];
    assign w_hop   = i_data[97:82];
    assign w_hops  = i_data[105:98];
    assign w_prof  = i_data[109:106];
    assign w_mtu   = i_data[125:110];
    assign w_link  = i_data[129:126];
    assign w_exp   = i_data[161:130];
    assign w_now   = i_data[193:162];

    assign w_key_ok = (w_owner != 16'd0) && (w_owner != r_bcast) && (w_sess != 32'd0)
                   && (w_path != 16'd0) && (w_dest != 16'd0) && (w_dest != r_bcast);
    assign w_inst_bad = !w_key_ok || (w_exp == 32'd0)
                   || ((w_hop == 16'd0) != (w_hops == 8'd0))
                   || ((w_hop == 16'd0) != (w_link == 4'd0))
                   || ((w_mtu != 16'd0) && ((w_prof == 4'd0) || (w_prof > r_maxprof)));

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.req        = t_req'(w_req);
        o_cmd.arg_bad    = (t_req'(w_req) == REQ_INSTALL) ? w_inst_bad :
                           (t_req'(w_req) == REQ_EXPIRE) ? 1'b0 : !w_key_ok;
        o_cmd.owner_path = {w_owner, w_path};
        o_cmd.session    = w_sess;
        o_cmd.dest       = w_dest;
        o_cmd.hop        = w_hop;
        o_cmd.hops       = w_hops;
        o_cmd.profile    = (w_mtu == 16'd0) ? 4'd0 : w_prof;
        o_cmd.mtu        = w_mtu;
        o_cmd.link       = w_link;
        o_cmd.expiry     = w_exp;
        o_cmd.now        = w_now;
    end
endmodule

// File: sv/pft_queue.sv
// ----------------------------------------------------------------------------
// pft_queue: command queue between front and back end
// Two-entry register FIFO of classified commands.
// ----------------------------------------------------------------------------
module pft_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pft_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pft_pkg::t_cmd o_cmd
);
    import pft_pkg::*;

    t_cmd        r_mem [QDepth];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
endmodule

// File: sv/pft_back.sv
// ----------------------------------------------------------------------------
// pft_back: table and request execution
// Parallel match over all entries, update, and a registered response.
// ----------------------------------------------------------------------------
module pft_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pft_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output pft_pkg::t_rsp o_rsp
);
    import pft_pkg::*;

    logic [TableEntries-1:0] r_vld;
    logic [31:0] r_op   [TableEntries];
    logic [31:0] r_sess [TableEntries];
    logic [15:0] r_dest [TableEntries];
    logic [32:0] r_route[TableEntries];
    logic [15:0] r_mtu  [TableEntries];
    logic [31:0] r_dl   [TableEntries];

    logic        r_ovalid;
    t_rsp        r_rsp;

    logic [TableEntries-1:0] w_id, w_exp;
    logic        w_idhit, w_free_any, w_take;
    logic [SlotW-1:0] w_id_i, w_free_i;
    logic [CntW-1:0]  w_cnt;
    t_rsp        w_rsp;
    logic        w_wr_new, w_wr_route;
    logic [32:0] w_route;

    always_comb begin
        w_idhit = 1'b0; w_id_i = '0; w_free_any = 1'b0; w_free_i = '0;
        w_cnt = '0;
        for (int i = 0; i < TableEntries; i++) begin
            w_id[i]  = r_vld[i] && (r_op[i] == i_cmd.owner_path)
                    && (r_sess[i] == i_cmd.session);
            w_exp[i] = r_vld[i] && deadline_reached(i_cmd.now, r_dl[i]);
            w_cnt    = w_cnt + CntW'(w_exp[i]);
        end
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (w_id[i]) begin w_idhit = 1'b1; w_id_i = SlotW'(i); end
            if (!r_vld[i]) begin w_free_any = 1'b1; w_free_i = SlotW'(i); end
        end
    end

    assign w_take = i_valid && (!r_ovalid || i_ready);
    assign o_pop  = w_take;
    assign w_route = {i_cmd.hop, i_cmd.hops, i_cmd.profile, i_cmd.link,
                      (i_cmd.hop == 16'd0)};

    always_comb begin
        w_rsp = '0;
        w_wr_new = 1'b0;
        w_wr_route = 1'b0;
        if (i_cmd.arg_bad) begin
            w_rsp.status = ST_ARG;
        end else begin
            unique case (i_cmd.req)
                REQ_INSTALL: begin
                    if (w_idhit) begin
                        w_rsp.slot = 4'(w_id_i);
                        if (r_dest[w_id_i] != i_cmd.dest) w_rsp.status = ST_ACCESS;
                        else w_wr_route = 1'b1;
                    end else if (w_free_any) begin
                        w_rsp.slot = 4'(w_free_i);
                        w_wr_new = 1'b1;
                    end else begin
                        w_rsp.status = ST_NOSPACE;
                    end
                end
                REQ_FIND, REQ_REVOKE: begin
                    if (w_idhit && r_dest[w_id_i] == i_cmd.dest) begin
                        w_rsp.slot = 4'(w_id_i);
                        if (i_cmd.req == REQ_FIND) begin
                            w_rsp.hit       = 1'b1;
                            w_rsp.fwd_hop   = r_route[w_id_i][32:17];
                            w_rsp.hops_left = r_route[w_id_i][16:9];
                            w_rsp.profile   = r_route[w_id_i][8:5];
                            w_rsp.link      = r_route[w_id_i][4:1];
                            w_rsp.terminal  = r_route[w_id_i][0];
                            w_rsp.mtu       = r_mtu[w_id_i];
                            w_rsp.deadline  = r_dl[w_id_i];
                            w_rsp.expired   = deadline_reached(i_cmd.now, r_dl[w_id_i]);
                        end
                    end else begin
                        w_rsp.status = ST_NOTFOUND;
                    end
                end
                REQ_EXPIRE: w_rsp.removed = 5'(w_cnt);
                default: w_rsp.status = ST_ARG;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_take) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (w_take && !i_cmd.arg_bad) begin
                if (w_wr_new) r_vld[w_free_i] <= 1'b1;
                if (i_cmd.req == REQ_EXPIRE) r_vld <= r_vld & ~w_exp;
                if (i_cmd.req == REQ_REVOKE && w_rsp.status == ST_OK)
                    r_vld[w_id_i] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp <= w_rsp;
            if (w_wr_new) begin
                r_op[w_free_i]   <= i_cmd.owner_path;
                r_sess[w_free_i] <= i_cmd.session;
                r_dest[w_free_i] <= i_cmd.dest;
                r_route[w_free_i] <= w_route;
                r_mtu[w_free_i]  <= i_cmd.mtu;
                r_dl[w_free_i]   <= i_cmd.expiry;
            end
            if (w_wr_route) begin
                r_route[w_id_i] <= w_route;
                r_mtu[w_id_i]   <= i_cmd.mtu;
                r_dl[w_id_i]    <= i_cmd.expiry;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    a_newslot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_wr_new) |-> !r_vld[w_free_i]) else $error("fill of busy slot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> $stable(r_rsp)) else $error("response changed");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_new && w_wr_route)) else $error("double write");
endmodule

// File: sv/path_forward_table_unit.sv
// ----------------------------------------------------------------------------
// path_forward_table_unit: path forwarding table with aging
// Sixteen-entry identity match table with install, find, revoke, expire.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  s_axis   in   request: tdata = req_type..now_time (tdata 200 bits)
//  m_axis   out  one result per request (tdata 96 bits)
//  cfg      in   register write, index 0 broadcast node, 1 max profile
//
//  A request passes the front check in its accept cycle, waits in a
//  two-entry queue, and executes in the back end one per cycle unless a
//  stalled result holds it; the result appears in the cycle after execution.
//  Reset clears the table valid bits and the queue at once.
//  A stalled result holds; the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module path_forward_table_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type, owner_node, owner_session, path_number, dest_node, hop_node,
    // hops_left, wire_profile, mtu_floor, link_id, expiry_time, now_time
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, hit, slot, out hop node, out_hops_left, out_profile, out_mtu,
    // out_link, out_terminal, out_deadline, out_expired, removed_count
    output logic [95:0]  m_axis_tdata
);
    import pft_pkg::*;

    t_cmd w_fcmd, w_qcmd;
    t_rsp w_rsp;
    logic w_push, w_full, w_pop, w_qvalid;

    pft_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata[193:0]),
        .o_push(w_push), .o_cmd(w_fcmd), .i_full(w_full)
    );

    pft_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_cmd(w_fcmd), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_qvalid), .o_cmd(w_qcmd)
    );

    pft_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qvalid), .i_cmd(w_qcmd), .o_pop(w_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_rsp(w_rsp)
    );

    assign m_axis_tdata = {1'b0, w_rsp.removed, w_rsp.expired, w_rsp.deadline,
                           w_rsp.terminal, w_rsp.link, w_rsp.mtu, w_rsp.profile,
                           w_rsp.hops_left, w_rsp.fwd_hop, w_rsp.slot, w_rsp.hit,
                           w_rsp.status};
endmodule

// File: verif/path_forward_table_unit_tb.sv
// ----------------------------------------------------------------------------
// path_forward_table_unit_tb: self-checking bench of the path forwarding table
// Drives install, find, revoke and expire beats with random gaps on both
// sides, predicts each result from a private copy of the table and compares
// every field of every result beat, in order, against the prediction.
// ----------------------------------------------------------------------------
module path_forward_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pft_pkg::*;

    localparam int NumRandom = 530;
    localparam int StallLimit = 5000;
    localparam int Entries = 16;

    // One request beat, fields in tdata order from bit 0 up.
    typedef struct {
        t_req        req;
        logic [15:0] owner;
        logic [31:0] sess;
        logic [15:0] path;
        logic [15:0] dest;
        logic [15:0] hop;
        logic [7:0]  hops;
        logic [3:0]  prof;
        logic [15:0] mtu;
        logic [3:0]  link;
        logic [31:0] expiry;
        logic [31:0] now;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_status     status;
        logic        hit;
        logic [3:0]  slot;
        logic [15:0] fwd_hop;
        logic [7:0]  hops_left;
        logic [3:0]  profile;
        logic [15:0] mtu;
        logic [3:0]  link;
        logic        terminal;
        logic [31:0] deadline;
        logic        expired;
        logic [4:0]  removed;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_idx;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // req_type, owner_node, owner_session, path_number, dest_node, hop_node,
    // hops_left, wire_profile, mtu_floor, link_id, expiry_time, now_time
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status, hit, slot, out hop node, out_hops_left, out_profile, out_mtu,
    // out_link, out_terminal, out_deadline, out_expired, removed_count
    logic [95:0]  m_axis_tdata;

    path_forward_table_unit dut (.*);

    // Predictor state: the table as the block should hold it.
    logic [15:0] bcast_node;
    logic [3:0]  max_prof;
    logic        tbl_valid [Entries];
    logic [15:0] tbl_owner [Entries];
    logic [15:0] tbl_path  [Entries];
    logic [31:0] tbl_sess  [Entries];
    logic [15:0] tbl_dest  [Entries];
    logic [15:0] tbl_hop   [Entries];
    logic [7:0]  tbl_hops  [Entries];
    logic [3:0]  tbl_prof  [Entries];
    logic [3:0]  tbl_link  [Entries];
    logic [15:0] tbl_mtu   [Entries];
    logic [31:0] tbl_dl    [Entries];

    t_answer pending_answers[$];
    int      error_count;
    int      idle_cycles;
    bit      pressure;     // when set, neither side idles
    bit      timed_out;

    // Identities handed out so far; random installs and lookups reuse them.
    logic [15:0] known_owner[$];
    logic [31:0] known_sess[$];
    logic [15:0] known_path[$];
    logic [15:0] known_dest[$];
    logic [31:0] clock_ms;    // notional time that random stimulus advances

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit node_good(logic [15:0] n);
        return n != 16'd0 && n != bcast_node;
    endfunction

    function automatic bit past_deadline(logic [31:0] now, logic [31:0] dl);
        logic [31:0] d;
        d = now - dl;
        return !d[31];
    endfunction

    function automatic bit same_id(int i, t_item it);
        return tbl_valid[i] && tbl_owner[i] == it.owner && tbl_path[i] == it.path
            && tbl_sess[i] == it.sess;
    endfunction

    // Apply one request to the shadow table and return its result.
    function automatic t_answer table_apply(t_item it);
        t_answer a;
        bit key_good;
        int free_slot;
        a = '{status: ST_OK, default: '0};
        key_good = node_good(it.owner) && it.sess != 0 && it.path != 0
            && node_good(it.dest);
        case (it.req)
            REQ_INSTALL: begin
                if (!key_good || it.expiry == 0 || ((it.hop == 0) != (it.hops == 0))
                        || ((it.hop == 0) != (it.link == 0))
                        || (it.mtu != 0 && (it.prof == 0 || it.prof > max_prof))) begin
                    a.status = ST_ARG;
                    return a;
                end
                free_slot = -1;
                for (int i = 0; i < Entries; i++) begin
                    if (same_id(i, it)) begin
                        a.slot = i[3:0];
                        if (tbl_dest[i] != it.dest) begin
                            a.status = ST_ACCESS;
                            return a;
                        end
                        free_slot = i;
                        break;
                    end
                    if (!tbl_valid[i] && free_slot < 0) free_slot = i;
                end
                if (free_slot < 0) begin
                    a.status = ST_NOSPACE;
                    return a;
                end
                tbl_valid[free_slot] = 1'b1;
                tbl_owner[free_slot] = it.owner;
                tbl_path[free_slot]  = it.path;
                tbl_sess[free_slot]  = it.sess;
                tbl_dest[free_slot]  = it.dest;
                tbl_hop[free_slot]   = it.hop;
                tbl_hops[free_slot]  = it.hops;
                tbl_prof[free_slot]  = (it.mtu == 0) ? 4'd0 : it.prof;
                tbl_link[free_slot]  = it.link;
                tbl_mtu[free_slot]   = it.mtu;
                tbl_dl[free_slot]    = it.expiry;
                a.slot = free_slot[3:0];
            end
            REQ_FIND, REQ_REVOKE: begin
                if (!key_good) begin
                    a.status = ST_ARG;
                    return a;
                end
                for (int i = 0; i < Entries; i++) begin
                    if (same_id(i, it) && tbl_dest[i] == it.dest) begin
                        a.slot = i[3:0];
                        if (it.req == REQ_REVOKE) begin
                            tbl_valid[i] = 1'b0;
                        end else begin
                            a.hit       = 1'b1;
                            a.fwd_hop   = tbl_hop[i];
                            a.hops_left = tbl_hops[i];
                            a.profile   = tbl_prof[i];
                            a.mtu       = tbl_mtu[i];
                            a.link      = tbl_link[i];
                            a.terminal  = (tbl_hop[i] == 0);
                            a.deadline  = tbl_dl[i];
                            a.expired   = past_deadline(it.now, tbl_dl[i]);
                        end
                        return a;
                    end
                end
                a.status = ST_NOTFOUND;
            end
            default: begin
                for (int i = 0; i < Entries; i++) begin
                    if (tbl_valid[i] && past_deadline(it.now, tbl_dl[i])) begin
                        tbl_valid[i] = 1'b0;
                        a.removed++;
                    end
                end
            end
        endcase
        return a;
    endfunction

    function automatic logic [199:0] pack_item(t_item it);
        return {6'd0, it.now, it.expiry, it.link, it.mtu, it.prof, it.hops, it.hop,
                it.dest, it.path, it.sess, it.owner, it.req};
    endfunction

    function automatic t_answer unpack_answer(logic [95:0] d);
        t_answer a;
        a.status    = t_status'(d[2:0]);
        a.hit       = d[3];
        a.slot      = d[7:4];
        a.fwd_hop   = d[23:8];
        a.hops_left = d[31:24];
        a.profile   = d[35:32];
        a.mtu       = d[51:36];
        a.link      = d[55:52];
        a.terminal  = d[56];
        a.deadline  = d[88:57];
        a.expired   = d[89];
        a.removed   = d[94:90];
        return a;
    endfunction

    function automatic bit want_gap();
        return !pressure && $urandom_range(99) < 20;
    endfunction

    // Result side: random backpressure, in-order compare, watchdog.
    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            idle_cycles   <= 0;
        end else begin
            m_axis_tready <= !want_gap();
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                got = unpack_answer(m_axis_tdata);
                if (pending_answers.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (got.status != want.status) begin
                        $error("status: expected %0d got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.hit != want.hit) begin
                        $error("hit: expected %0d got %0d", want.hit, got.hit);
                        error_count++;
                    end
                    if (got.slot != want.slot) begin
                        $error("slot: expected %0d got %0d", want.slot, got.slot);
                        error_count++;
                    end
                    if (got.fwd_hop != want.fwd_hop) begin
                        $error("out hop node: expected %0h got %0h",
                               want.fwd_hop, got.fwd_hop);
                        error_count++;
                    end
                    if (got.hops_left != want.hops_left) begin
                        $error("out_hops_left: expected %0d got %0d",
                               want.hops_left, got.hops_left);
                        error_count++;
                    end
                    if (got.profile != want.profile) begin
                        $error("out_profile: expected %0d got %0d",
                               want.profile, got.profile);
                        error_count++;
                    end
                    if (got.mtu != want.mtu) begin
                        $error("out_mtu: expected %0d got %0d", want.mtu, got.mtu);
                        error_count++;
                    end
                    if (got.link != want.link) begin
                        $error("out_link: expected %0d got %0d", want.link, got.link);
                        error_count++;
                    end
                    if (got.terminal != want.terminal) begin
                        $error("out_terminal: expected %0d got %0d",
                               want.terminal, got.terminal);
                        error_count++;
                    end
                    if (got.deadline != want.deadline) begin
                        $error("out_deadline: expected %0h got %0h",
                               want.deadline, got.deadline);
                        error_count++;
                    end
                    if (got.expired != want.expired) begin
                        $error("out_expired: expected %0d got %0d",
                               want.expired, got.expired);
                        error_count++;
                    end
                    if (got.removed != want.removed) begin
                        $error("removed_count: expected %0d got %0d",
                               want.removed, got.removed);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= StallLimit) timed_out <= 1'b1;
    end

    // Send one beat: hold tvalid until accepted, predict at acceptance.
    // Drop tvalid only while idling, so back-to-back beats keep it high.
    task automatic send_beat(t_item it, bit gaps);
        while (gaps && want_gap()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        do @(posedge i_clk); while (!s_axis_tready);
        pending_answers.push_back(table_apply(it));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_BCAST) bcast_node = val;
        else max_prof = val[3:0];
    endtask

    // Build a well-formed install for an identity with random route content.
    function automatic t_item good_install(logic [15:0] ow, logic [31:0] se,
                                           logic [15:0] pa, logic [15:0] de);
        t_item it;
        it.req = REQ_INSTALL;
        it.owner = ow; it.sess = se; it.path = pa; it.dest = de;
        if ($urandom_range(2) == 0) begin
            it.hop = 0; it.hops = 0; it.link = 0;
        end else begin
            it.hop  = 16'($urandom_range(65535, 1));
            it.hops = 8'($urandom_range(255, 1));
            it.link = 4'($urandom_range(15, 1));
        end
        it.mtu  = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 1));
        it.prof = it.mtu == 0 ? 4'($urandom) : 4'($urandom_range(max_prof, 1));
        it.expiry = clock_ms + $urandom_range(400, 1);
        if (it.expiry == 0) it.expiry = 1;
        it.now = $urandom;
        return it;
    endfunction

    function automatic logic [15:0] rand_node();
        logic [15:0] n;
        do n = 16'($urandom); while (!node_good(n));
        return n;
    endfunction

    // Random request: mostly well-formed traffic on known identities.
    function automatic t_item random_item();
        t_item it;
        int k, pick;
        pick = $urandom_range(99);
        if (known_owner.size() < 24 || pick < 10) begin
            known_owner.push_back(rand_node());
            known_sess.push_back($urandom_range(32'hFFFF_FFFF, 1));
            known_path.push_back(16'($urandom_range(65535, 1)));
            known_dest.push_back(rand_node());
        end
        k = $urandom_range(known_owner.size() - 1);
        it = good_install(known_owner[k], known_sess[k], known_path[k], known_dest[k]);
        it.now = clock_ms + $urandom_range(500) - 250;
        if (pick < 40) begin
            it.req = REQ_INSTALL;
            if ($urandom_range(9) == 0) it.dest = rand_node();   // access conflict
        end else if (pick < 65) begin
            it.req = REQ_FIND;
        end else if (pick < 78) begin
            it.req = REQ_REVOKE;
        end else if (pick < 86) begin
            it.req = REQ_EXPIRE;
            clock_ms += $urandom_range(150);
            it.now = clock_ms;
        end else begin
            // Noise: raw random fields across the whole range.
            it.req = t_req'($urandom_range(3));
            it.owner = 16'($urandom); it.sess = $urandom; it.path = 16'($urandom);
            it.dest = 16'($urandom); it.hop = 16'($urandom); it.hops = 8'($urandom);
            it.prof = 4'($urandom); it.mtu = 16'($urandom); it.link = 4'($urandom);
            it.expiry = $urandom; it.now = $urandom;
            if ($urandom_range(3) == 0) it.owner = bcast_node;
            if ($urandom_range(3) == 0) it.dest = 16'd0;
        end
        return it;
    endfunction

    // Directed table: request, whether an answer is typed in, and that answer.
    typedef struct {
        t_item   it;
        bit      typed;
        t_answer ans;
    } t_row;

    t_row directed[$];

    task automatic add_row(t_item it, bit typed, t_answer ans);
        t_row r;
        r.it = it; r.typed = typed; r.ans = ans;
        directed.push_back(r);
    endtask

    task automatic build_directed();
        t_item b, x;
        t_answer none, ok;
        none = '{status: ST_OK, default: '0};
        ok = none;
        b = good_install(16'h0001, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE);
        b.hop = 16'hFFFF; b.hops = 8'hFF; b.link = 4'hF;
        b.mtu = 16'hFFFF; b.prof = 4'd7; b.expiry = 32'hFFFF_FFFF; b.now = 0;
        // Lookups on an empty table miss.
        x = b; x.req = REQ_FIND;
        ok.status = ST_NOTFOUND; add_row(x, 1, ok);
        x.req = REQ_EXPIRE; x.now = 32'hFFFF_FFFF;
        add_row(x, 1, none);
        // Fill slot 0 at the field extremes, read it back.
        add_row(b, 1, none);
        x = b; x.req = REQ_FIND; x.now = 32'h7FFF_FFFE;
        add_row(x, 0, none);
        x.now = 32'hFFFF_FFFF;    // deadline reached exactly
        add_row(x, 0, none);
        // Same identity, other destination: access conflict on slot 0.
        x = b; x.dest = 16'h0002;
        ok = none; ok.status = ST_ACCESS; add_row(x, 1, ok);
        // Update in place: terminal route, mtu zero stores profile zero.
        x = b; x.hop = 0; x.hops = 0; x.link = 0; x.mtu = 0; x.prof = 4'hF;
        add_row(x, 1, none);
        x.req = REQ_FIND; add_row(x, 0, none);
        // Argument errors.
        ok = none; ok.status = ST_ARG;
        x = b; x.owner = 16'hFFFF; add_row(x, 1, ok);
        x = b; x.sess = 0; add_row(x, 1, ok);
        x = b; x.path = 0; add_row(x, 1, ok);
        x = b; x.dest = 0; add_row(x, 1, ok);
        x = b; x.expiry = 0; add_row(x, 1, ok);
        x = b; x.hops = 0; add_row(x, 1, ok);
        x = b; x.link = 0; add_row(x, 1, ok);
        x = b; x.prof = 0; add_row(x, 1, ok);
        x = b; x.prof = 4'd8; add_row(x, 1, ok);
        x = b; x.req = REQ_FIND; x.owner = 0; add_row(x, 1, ok);
        x = b; x.req = REQ_REVOKE; x.dest = 16'hFFFF; add_row(x, 1, ok);
        // Revoke, then miss.
        x = b; x.req = REQ_REVOKE; add_row(x, 1, none);
        x.req = REQ_FIND; ok = none; ok.status = ST_NOTFOUND; add_row(x, 1, ok);
        // Fill the table, overflow, then expire everything.
        for (int i = 0; i < Entries; i++) begin
            x = b; x.path = 16'(i + 2); x.expiry = 32'h8000_0000 + i;
            ok = none; ok.slot = i[3:0]; add_row(x, 1, ok);
        end
        x = b; x.path = 16'h0100;
        ok = none; ok.status = ST_NOSPACE; add_row(x, 1, ok);
        x.req = REQ_EXPIRE; x.now = 32'h8000_000F;
        ok = none; ok.removed = 5'd16; add_row(x, 1, ok);
    endtask

    initial begin
        t_answer pred;
        error_count = 0;
        pressure = 1'b0;
        clock_ms = 32'd1000;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BCAST;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        bcast_node = 16'hFFFF;
        max_prof = 4'd7;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

        fork
            begin
                repeat (11) @(posedge i_clk);
                i_rst_n <= 1'b1;
                @(posedge i_clk);

                // Directed part, reset register values.
                build_directed();
                foreach (directed[r]) begin
                    send_beat(directed[r].it, 1);
                    pred = pending_answers[pending_answers.size() - 1];
                    if (directed[r].typed && pred != directed[r].ans) begin
                        $error("row %0d: typed-in answer disagrees with prediction", r);
                        error_count++;
                    end
                end
                drain();

                // Random part, phases over register settings incl. extremes.
                for (int ph = 0; ph < 5; ph++) begin
                    case (ph)
                        0: begin write_reg(CFG_BCAST, 16'd1); write_reg(CFG_MAXPROF, 16'd15); end
                        1: begin write_reg(CFG_BCAST, 16'hFFFF); write_reg(CFG_MAXPROF, 16'd1); end
                        2: begin
                            write_reg(CFG_BCAST, 16'($urandom_range(65535, 1)));
                            write_reg(CFG_MAXPROF, 16'($urandom_range(15, 1)));
                        end
                        default: ;
                    endcase
                    pressure = (ph == 3);   // one stretch with no idling at all
                    for (int n = 0; n < NumRandom / 5; n++) begin
                        // Once, in the last phase, hold the sender until every result is back.
                        if (ph == 4 && n == 40) drain();
                        send_beat(random_item(), 1);
                    end
                    pressure = 1'b0;
                    drain();
                end
            end
            begin
                wait (timed_out);
            end
        join_any

        if (timed_out) begin
            $display("Testbench completed WITH ERRORS");
        end else if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
